[design/wsfp_pkg.sv]
`default_nettype none

package wsfp_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT2 = 3'd2,
        PH_EXT8 = 3'd3,
        PH_MASK = 3'd4,
        PH_PAY  = 3'd5
    } t_phase;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [3:0] ERR_OPCODE     = 4'd0;
    localparam logic [3:0] ERR_FRAG_CTRL  = 4'd1;
    localparam logic [3:0] ERR_EXP_CONT   = 4'd2;
    localparam logic [3:0] ERR_CTRL_LEN   = 4'd3;
    localparam logic [3:0] ERR_LEN2_MIN   = 4'd4;
    localparam logic [3:0] ERR_LEN8_MIN   = 4'd5;
    localparam logic [3:0] ERR_LEN_MSB    = 4'd6;
    localparam logic [3:0] ERR_MASKED     = 4'd7;
    localparam logic [3:0] ERR_UNMASKED   = 4'd8;

    localparam logic [3:0] OP_CONT        = 4'd0;
    localparam logic [3:0] OPCODE_MAX     = 4'd10;
    localparam logic [6:0] CTRL_LEN_MAX   = 7'd125;
    localparam logic [6:0] LEN7_EXT2      = 7'd126;
    localparam logic [6:0] LEN7_EXT8      = 7'd127;
    localparam logic [3:0] EXT2_BYTES     = 4'd2;
    localparam logic [3:0] EXT8_BYTES     = 4'd8;
    localparam logic [3:0] MASK_BYTES     = 4'd4;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  fbc;
        logic [7:0]  fhb;
        logic [63:0] acc;
        logic [31:0] key;
        logic [63:0] rem;
        logic [1:0]  midx;
        logic        frag_active;
        logic [3:0]  frag_opcode;
        logic        err;
        logic        masked;
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [3:0]  opcode;
        logic        fin;
        logic [2:0]  rsv;
        logic        masked;
        logic [62:0] length;
        logic        last;
        logic [3:0]  err_code;
    } t_result;

endpackage

`default_nettype wire

[design/websocket_frame_parser.sv]
// A result is registered and shows on the master side in the cycle after its byte.
// Throughput: one byte per cycle; the single output register frees itself in the same
// cycle it is taken, so the input stalls only while a result waits on the master side.
// Reset (synchronous, active low) returns the parser to the first header byte, clears
// the sticky error and fragment state, and selects the client endpoint.
`default_nettype none

module websocket_frame_parser #(
    parameter int ADDR_W = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,     // data_byte
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // out_byte[7:0], frame_opcode[11:8], fin_flag[12], reserved_bits[15:13],
    // masked_flag[16], frame_length[79:17], error_code[83:80], zero fill[87:84]
    output logic [87:0]            o_m_tdata,
    output logic [1:0]             o_m_tuser,     // item_kind
    output logic                   o_m_tlast,     // last_of_frame
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    wsfp_pkg::t_state  r_state;
    wsfp_pkg::t_state  n_state;
    wsfp_pkg::t_result w_res;
    wsfp_pkg::t_result r_res;
    logic              r_out_valid;
    logic              r_server;
    logic              w_in_acc;
    logic              w_reg0;

    assign w_reg0     = (paddr[ADDR_W-1:2] == '0);
    assign pready     = 1'b1;
    assign prdata     = w_reg0 ? {31'd0, r_server} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg0) begin
            r_server <= pwdata[0];
        end
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    wsfp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_s_tdata),
        .i_server (r_server),
        .o_state  (n_state),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_state <= n_state;
            end
            if (w_in_acc && w_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res.valid) begin
            r_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;
    assign o_m_tdata  = {4'd0, r_res.err_code, r_res.length, r_res.masked, r_res.rsv,
                         r_res.fin, r_res.opcode, r_res.out_byte};

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err |=> r_state.err)
        else $error("error latch cleared without reset");

    a_pay_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == wsfp_pkg::PH_PAY |-> r_state.rem != 64'd0)
        else $error("payload phase with no bytes remaining");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == wsfp_pkg::KIND_ERR) |-> (o_m_tdata[79:0] == '0 && !o_m_tlast))
        else $error("error item carries frame fields");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_state.err) |=> !(o_m_tvalid && $rose(o_m_tvalid)))
        else $error("item produced after error latched");

endmodule

`default_nettype wire

[design/wsfp_step.sv]
`default_nettype none

module wsfp_step (
    input  wire wsfp_pkg::t_state  i_state,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_server,
    output wsfp_pkg::t_state       o_state,
    output wsfp_pkg::t_result      o_res
);

    wsfp_pkg::t_state n;
    logic             ld;
    logic             hdr;
    logic             pay;
    logic             ef;
    logic             err;
    logic             last;
    logic [3:0]       code;
    logic [7:0]       pay_byte;

    logic [3:0]       op;
    logic             fin;
    logic             ctrl;
    logic [6:0]       len7;
    logic [3:0]       fbc_inc;
    logic [31:0]      key_sh;

    assign op      = i_state.fhb[3:0];
    assign fin     = i_state.fhb[7];
    assign ctrl    = op[3];
    assign len7    = i_byte[6:0];
    assign fbc_inc = 4'(i_state.fbc + 4'd1);
    assign key_sh  = i_state.key >> {~i_state.midx, 3'b000};

    always_comb begin
        n        = i_state;
        ld       = 1'b0;
        hdr      = 1'b0;
        pay      = 1'b0;
        ef       = 1'b0;
        err      = 1'b0;
        last     = 1'b0;
        code     = wsfp_pkg::ERR_OPCODE;
        pay_byte = 8'd0;
        if (!i_state.err) begin
            unique case (i_state.phase)
                wsfp_pkg::PH_HDR0: begin
                    n.fhb   = i_byte;
                    n.phase = wsfp_pkg::PH_HDR1;
                end
                wsfp_pkg::PH_HDR1: begin
                    if (op > wsfp_pkg::OPCODE_MAX) begin
                        err  = 1'b1;
                        code = wsfp_pkg::ERR_OPCODE;
                    end else if (ctrl && !fin) begin
                        err  = 1'b1;
                        code = wsfp_pkg::ERR_FRAG_CTRL;
                    end else if (i_state.frag_active && op != wsfp_pkg::OP_CONT) begin
                        err  = 1'b1;
                        code = wsfp_pkg::ERR_EXP_CONT;
                    end else if (ctrl && len7 > wsfp_pkg::CTRL_LEN_MAX) begin
                        err  = 1'b1;
                        code = wsfp_pkg::ERR_CTRL_LEN;
                    end else begin
                        n.masked = i_byte[7];
                        n.fbc    = 4'd0;
                        if (len7 == wsfp_pkg::LEN7_EXT2) begin
                            n.acc   = 64'd0;
                            n.phase = wsfp_pkg::PH_EXT2;
                        end else if (len7 == wsfp_pkg::LEN7_EXT8) begin
                            n.acc   = 64'd0;
                            n.phase = wsfp_pkg::PH_EXT8;
                        end else begin
                            n.acc = {57'd0, len7};
                            ld    = 1'b1;
                        end
                    end
                end
                wsfp_pkg::PH_EXT2: begin
                    n.acc = {48'd0, i_state.acc[7:0], i_byte};
                    n.fbc = fbc_inc;
                    if (fbc_inc >= wsfp_pkg::EXT2_BYTES) begin
                        if (n.acc <= 64'd125) begin
                            err  = 1'b1;
                            code = wsfp_pkg::ERR_LEN2_MIN;
                        end else begin
                            ld = 1'b1;
                        end
                    end
                end
                wsfp_pkg::PH_EXT8: begin
                    n.acc = {i_state.acc[55:0], i_byte};
                    n.fbc = fbc_inc;
                    if (fbc_inc >= wsfp_pkg::EXT8_BYTES) begin
                        if (n.acc <= 64'hFFFF) begin
                            err  = 1'b1;
                            code = wsfp_pkg::ERR_LEN8_MIN;
                        end else if (n.acc[63]) begin
                            err  = 1'b1;
                            code = wsfp_pkg::ERR_LEN_MSB;
                        end else begin
                            ld = 1'b1;
                        end
                    end
                end
                wsfp_pkg::PH_MASK: begin
                    n.key = {i_state.key[23:0], i_byte};
                    n.fbc = fbc_inc;
                    if (fbc_inc >= wsfp_pkg::MASK_BYTES) begin
                        hdr = 1'b1;
                    end
                end
                wsfp_pkg::PH_PAY: begin
                    pay      = 1'b1;
                    pay_byte = i_byte ^ (i_state.masked ? key_sh[7:0] : 8'd0);
                    n.midx   = 2'(i_state.midx + 2'd1);
                    if (i_state.rem != 64'd0) begin
                        n.rem = 64'(i_state.rem - 64'd1);
                    end
                    last = (n.rem == 64'd0);
                    ef   = last;
                end
                default: begin
                    n.phase = wsfp_pkg::PH_HDR0;
                end
            endcase
            if (ld) begin
                if (n.masked && !i_server) begin
                    err  = 1'b1;
                    code = wsfp_pkg::ERR_MASKED;
                end else if (!n.masked && i_server) begin
                    err  = 1'b1;
                    code = wsfp_pkg::ERR_UNMASKED;
                end else if (n.masked) begin
                    n.phase = wsfp_pkg::PH_MASK;
                    n.fbc   = 4'd0;
                    n.key   = 32'd0;
                end else begin
                    hdr = 1'b1;
                end
            end
            if (hdr) begin
                n.rem  = n.acc;
                n.midx = 2'd0;
                last   = (n.acc == 64'd0);
                ef     = last;
                if (!last) begin
                    n.phase = wsfp_pkg::PH_PAY;
                end
            end
            if (ef) begin
                if (!ctrl) begin
                    if (fin) begin
                        n.frag_active = 1'b0;
                    end else if (!i_state.frag_active) begin
                        n.frag_active = 1'b1;
                        n.frag_opcode = op;
                    end
                end
                n.phase = wsfp_pkg::PH_HDR0;
            end
            if (err) begin
                n.err = 1'b1;
            end
        end
    end

    assign o_state = n;

    always_comb begin
        o_res       = '0;
        o_res.valid = err | hdr | pay;
        if (err) begin
            o_res.kind     = wsfp_pkg::KIND_ERR;
            o_res.err_code = code;
        end else begin
            o_res.kind     = pay ? wsfp_pkg::KIND_PAY : wsfp_pkg::KIND_HDR;
            o_res.out_byte = pay_byte;
            o_res.opcode   = (!ctrl && !fin && i_state.frag_active) ? i_state.frag_opcode : op;
            o_res.fin      = fin;
            o_res.rsv      = i_state.fhb[6:4];
            o_res.masked   = n.masked;
            o_res.length   = n.acc[62:0];
            o_res.last     = last;
        end
    end

endmodule

`default_nettype wire

[test/wsfp_frame_checker.sv]
`timescale 1ns / 1ps

module wsfp_frame_checker #(
    parameter logic [2:0] ENDPOINT_ADDR = 3'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [87:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_header_count,
    output int               o_byte_count,
    output int               o_error_count
);
    import wsfp_pkg::*;

    localparam logic [3:0] OP_CTRL_MIN = 4'd8;

    t_phase      ph;
    logic [3:0]  fbc;
    logic [7:0]  fhb;
    logic [63:0] acc;
    logic [31:0] key;
    logic [63:0] rem;
    logic [1:0]  midx;
    logic        frag_act;
    logic [3:0]  frag_op;
    logic        err_lat;
    logic        masked;
    logic        server;

    t_result frame_expect_q[$];
    int      mismatches;
    int      headers_seen;
    int      bytes_seen;
    int      errors_seen;

    function automatic t_result frame_item(input logic [1:0] kind, input logic [7:0] b,
                                           input logic last);
        t_result r;
        logic [3:0] op;
        op = fhb[3:0];
        r = '0;
        r.valid = 1'b1;
        r.kind = kind;
        r.out_byte = b;
        r.opcode = (op < OP_CTRL_MIN && !fhb[7] && frag_act) ? frag_op : op;
        r.fin = fhb[7];
        r.rsv = fhb[6:4];
        r.masked = masked;
        r.length = acc[62:0];
        r.last = last;
        return r;
    endfunction

    function automatic t_result error_item(input logic [3:0] code);
        t_result r;
        err_lat = 1'b1;
        r = '0;
        r.valid = 1'b1;
        r.kind = KIND_ERR;
        r.err_code = code;
        return r;
    endfunction

    // Message tracking moves only when a frame ends.
    function automatic void finish_frame();
        if (fhb[3:0] < OP_CTRL_MIN) begin
            if (fhb[7]) begin
                frag_act = 1'b0;
            end else if (!frag_act) begin
                frag_act = 1'b1;
                frag_op = fhb[3:0];
            end
        end
        ph = PH_HDR0;
    endfunction

    function automatic bit open_payload(output t_result r);
        rem = acc;
        midx = 2'd0;
        if (acc == 64'd0) begin
            r = frame_item(KIND_HDR, 8'd0, 1'b1);
            finish_frame();
        end else begin
            r = frame_item(KIND_HDR, 8'd0, 1'b0);
            ph = PH_PAY;
        end
        return 1'b1;
    endfunction

    function automatic bit length_ready(output t_result r);
        r = '0;
        if (masked && !server) begin
            r = error_item(ERR_MASKED);
            return 1'b1;
        end
        if (!masked && server) begin
            r = error_item(ERR_UNMASKED);
            return 1'b1;
        end
        if (masked) begin
            ph = PH_MASK;
            fbc = 4'd0;
            key = 32'd0;
            return 1'b0;
        end
        return open_payload(r);
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        logic [3:0] op;
        logic [6:0] len7;
        logic [7:0] v;
        logic       last;
        r = '0;
        if (err_lat) return 1'b0;
        case (ph)
            PH_HDR0: begin
                fhb = b;
                ph = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                op = fhb[3:0];
                len7 = b[6:0];
                if (op > OPCODE_MAX) begin
                    r = error_item(ERR_OPCODE);
                    return 1'b1;
                end
                if (op >= OP_CTRL_MIN && !fhb[7]) begin
                    r = error_item(ERR_FRAG_CTRL);
                    return 1'b1;
                end
                if (frag_act && op != OP_CONT) begin
                    r = error_item(ERR_EXP_CONT);
                    return 1'b1;
                end
                masked = b[7];
                if (op >= OP_CTRL_MIN && len7 > CTRL_LEN_MAX) begin
                    r = error_item(ERR_CTRL_LEN);
                    return 1'b1;
                end
                fbc = 4'd0;
                if (len7 == LEN7_EXT2) begin
                    acc = 64'd0;
                    ph = PH_EXT2;
                    return 1'b0;
                end
                if (len7 == LEN7_EXT8) begin
                    acc = 64'd0;
                    ph = PH_EXT8;
                    return 1'b0;
                end
                acc = 64'(len7);
                return length_ready(r);
            end
            PH_EXT2: begin
                acc = {48'd0, acc[7:0], b};
                fbc = fbc + 4'd1;
                if (fbc < EXT2_BYTES) return 1'b0;
                if (acc <= 64'(CTRL_LEN_MAX)) begin
                    r = error_item(ERR_LEN2_MIN);
                    return 1'b1;
                end
                return length_ready(r);
            end
            PH_EXT8: begin
                acc = {acc[55:0], b};
                fbc = fbc + 4'd1;
                if (fbc < EXT8_BYTES) return 1'b0;
                if (acc <= 64'hFFFF) begin
                    r = error_item(ERR_LEN8_MIN);
                    return 1'b1;
                end
                if (acc[63]) begin
                    r = error_item(ERR_LEN_MSB);
                    return 1'b1;
                end
                return length_ready(r);
            end
            PH_MASK: begin
                key = {key[23:0], b};
                fbc = fbc + 4'd1;
                if (fbc < MASK_BYTES) return 1'b0;
                return open_payload(r);
            end
            PH_PAY: begin
                v = b;
                if (masked) v = v ^ 8'(key >> (24 - 8 * midx));
                midx = midx + 2'd1;
                if (rem != 64'd0) rem = rem - 64'd1;
                last = (rem == 64'd0);
                r = frame_item(KIND_PAY, v, last);
                if (last) finish_frame();
                return 1'b1;
            end
            default: begin
                ph = PH_HDR0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            ph = PH_HDR0;
            fbc = 4'd0;
            fhb = 8'd0;
            acc = 64'd0;
            key = 32'd0;
            rem = 64'd0;
            midx = 2'd0;
            frag_act = 1'b0;
            frag_op = 4'd0;
            err_lat = 1'b0;
            masked = 1'b0;
            server = 1'b0;
            frame_expect_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '0;
                got.kind = i_m_tuser;
                got.out_byte = i_m_tdata[7:0];
                got.opcode = i_m_tdata[11:8];
                got.fin = i_m_tdata[12];
                got.rsv = i_m_tdata[15:13];
                got.masked = i_m_tdata[16];
                got.length = i_m_tdata[79:17];
                got.err_code = i_m_tdata[83:80];
                got.last = i_m_tlast;
                if (frame_expect_q.size() == 0) begin
                    $display("%0t: result with nothing expected, kind %0h, data %0h",
                             $time, got.kind, i_m_tdata);
                    mismatches++;
                end else begin
                    want = frame_expect_q.pop_front();
                    check_field("item_kind", want.kind, got.kind);
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("frame_opcode", want.opcode, got.opcode);
                    check_field("fin_flag", want.fin, got.fin);
                    check_field("reserved_bits", want.rsv, got.rsv);
                    check_field("masked_flag", want.masked, got.masked);
                    check_field("frame_length", want.length, got.length);
                    check_field("last_of_frame", want.last, got.last);
                    check_field("error_code", want.err_code, got.err_code);
                    if (want.kind == KIND_HDR) headers_seen++;
                    else if (want.kind == KIND_PAY) bytes_seen++;
                    else errors_seen++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (parse_byte(i_s_tdata, pred)) frame_expect_q.push_back(pred);
            end
            if (i_psel && i_penable && i_pready && i_paddr == ENDPOINT_ADDR) begin
                if (i_pwrite) begin
                    server = i_pwdata[0];
                end else if (i_prdata !== {31'd0, server}) begin
                    $display("%0t: endpoint readback mismatch, expected %0h, got %0h",
                             $time, {31'd0, server}, i_prdata);
                    mismatches++;
                end
            end
        end
        o_pending <= frame_expect_q.size();
        o_fail_count <= mismatches;
        o_header_count <= headers_seen;
        o_byte_count <= bytes_seen;
        o_error_count <= errors_seen;
    end

endmodule

[test/websocket_frame_parser_tb.sv]
`timescale 1ns / 1ps

module websocket_frame_parser_tb;
    import wsfp_pkg::*;

    localparam logic [2:0] REG_ENDPOINT = 3'd0;
    localparam logic [2:0] REG_SPARE    = 3'd4;
    localparam logic [3:0] OP_TEXT      = 4'd1;
    localparam logic [3:0] OP_BINARY    = 4'd2;
    localparam logic [3:0] OP_CLOSE     = 4'd8;
    localparam logic [3:0] OP_PING      = 4'd9;
    localparam logic [3:0] OP_PONG      = 4'd10;
    localparam int         FULL_FRAME   = 32'h7FFF_FFFF;
    localparam int         ITEM_TARGET  = 1550;
    localparam int         STALL_LIMIT  = 2000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int header_count;
    int byte_count;
    int error_count;

    logic calm = 1'b0;
    bit   msg_open;
    bit   server_role;
    int   sent_items;
    int   rand_start;
    int   tail_case;
    int   stall_left;
    int   idle_cycles;

    websocket_frame_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    wsfp_frame_checker #(
        .ENDPOINT_ADDR (REG_ENDPOINT)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_m_tlast      (m_tlast),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_header_count (header_count),
        .o_byte_count   (byte_count),
        .o_error_count  (error_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Most gaps are short, a few are long, and calm stretches have none.
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk) begin : ready_gen
        int n;
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            n = idle_len();
            m_tready <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no traffic for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        sent_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_role(input bit srv);
        wait_idle();
        apb_access(1'b1, REG_ENDPOINT, {31'($urandom), srv});
        apb_access(1'b0, REG_ENDPOINT, 32'd0);
        server_role = srv;
    endtask

    function automatic logic [7:0] hdr0(input bit fin, input logic [3:0] op);
        return {fin, 3'($urandom_range(0, 7)), op};
    endfunction

    function automatic logic [7:0] open_hdr();
        return hdr0(1'b1, msg_open ? OP_CONT : OP_TEXT);
    endfunction

    // Uses the shortest length encoding, so no frame sent here trips a minimal-length check.
    task automatic send_frame(input bit fin, input logic [3:0] op, input bit mask_on,
                              input logic [63:0] len, input int pay_limit);
        logic [31:0] key;
        logic [6:0]  len7;
        int          n;
        key = $urandom;
        if (len > 64'hFFFF) len7 = LEN7_EXT8;
        else if (len > 64'(CTRL_LEN_MAX)) len7 = LEN7_EXT2;
        else len7 = len[6:0];
        send_byte(hdr0(fin, op));
        send_byte({mask_on, len7});
        if (len7 == LEN7_EXT2) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        if (len7 == LEN7_EXT8) begin
            for (n = 7; n >= 0; n--) send_byte(len[8*n +: 8]);
        end
        if (mask_on) begin
            for (n = 3; n >= 0; n--) send_byte(key[8*n +: 8]);
        end
        for (n = 0; n < pay_limit && n < len; n++) send_byte(8'($urandom));
        if (op < OP_CLOSE) begin
            if (fin) msg_open = 1'b0;
            else if (!msg_open) msg_open = 1'b1;
        end
    endtask

    task automatic random_frame();
        int          r;
        bit          fin;
        logic [3:0]  op;
        logic [63:0] len;
        r = $urandom_range(0, 99);
        if (msg_open) begin
            op = OP_CONT;
            fin = ($urandom_range(0, 2) == 0);
        end else if (r < 15) begin
            op = 4'($urandom_range(OP_CLOSE, OP_PONG));
            fin = 1'b1;
        end else if (r < 25) begin
            op = OP_CONT;
            fin = $urandom_range(0, 1);
        end else begin
            op = 4'($urandom_range(1, 7));
            fin = ($urandom_range(0, 9) < 6);
        end
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 6);
        else if (r < 88) len = $urandom_range(7, 40);
        else if (r < 91) len = 64'(CTRL_LEN_MAX);
        else if (r < 94) len = 64'd0;
        else len = $urandom_range(126, 200);
        if (op >= OP_CLOSE && len > 64'(CTRL_LEN_MAX)) len = $urandom_range(0, 125);
        send_frame(fin, op, server_role, len, FULL_FRAME);
    endtask

    initial begin
        int seg;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b1, REG_SPARE, $urandom);
        set_role(1'b0);
        send_frame(1'b1, OP_TEXT, 1'b0, 64'd0, FULL_FRAME);
        send_frame(1'b0, OP_BINARY, 1'b0, 64'd1, FULL_FRAME);
        send_frame(1'b0, OP_CONT, 1'b0, 64'd1, FULL_FRAME);
        send_frame(1'b1, OP_CONT, 1'b0, 64'd2, FULL_FRAME);
        send_frame(1'b1, OP_CONT, 1'b0, 64'd0, FULL_FRAME);
        send_frame(1'b1, OP_PING, 1'b0, 64'd0, FULL_FRAME);
        send_frame(1'b1, OP_PONG, 1'b0, 64'd1, FULL_FRAME);
        send_frame(1'b0, OP_CONT, 1'b0, 64'd0, FULL_FRAME);
        send_frame(1'b1, OP_CONT, 1'b0, 64'd0, FULL_FRAME);
        set_role(1'b1);
        send_frame(1'b1, OP_CLOSE, 1'b1, 64'd2, FULL_FRAME);

        // The smallest length that needs the two-byte form, carried in full once.
        send_frame(1'b1, OP_BINARY, 1'b1, 64'd126, FULL_FRAME);

        rand_start = sent_items;
        while (sent_items - rand_start < ITEM_TARGET) begin
            seg = (sent_items - rand_start) * 3 / ITEM_TARGET;
            if (server_role != (seg != 1)) set_role(seg != 1);
            calm <= ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 29) == 0) wait_idle();
            random_frame();
        end
        calm <= 1'b0;
        set_role($urandom_range(0, 1));

        // The error latches until reset, so at most one protocol error ends the run.
        tail_case = $urandom_range(0, 8);
        case (tail_case)
            0: begin
                send_byte(hdr0(1'b1, 4'($urandom_range(11, 15))));
                send_byte(8'($urandom));
            end
            1: begin
                send_byte(hdr0(1'b0, 4'($urandom_range(OP_CLOSE, OP_PONG))));
                send_byte(8'($urandom));
            end
            2: begin
                if (!msg_open) send_frame(1'b0, OP_TEXT, server_role, 64'd2, FULL_FRAME);
                send_byte(hdr0(1'b1, 4'($urandom_range(1, OPCODE_MAX))));
                send_byte(8'($urandom));
            end
            3: begin
                if (msg_open) send_frame(1'b1, OP_CONT, server_role, 64'd1, FULL_FRAME);
                send_byte(hdr0(1'b1, 4'($urandom_range(OP_CLOSE, OP_PONG))));
                send_byte({server_role, 7'($urandom_range(126, 127))});
            end
            4: begin
                send_byte(open_hdr());
                send_byte({server_role, LEN7_EXT2});
                send_byte(8'd0);
                send_byte(8'($urandom_range(0, 125)));
            end
            5: begin
                send_byte(open_hdr());
                send_byte({server_role, LEN7_EXT8});
                repeat (6) send_byte(8'd0);
                repeat (2) send_byte(8'($urandom));
            end
            6: begin
                send_byte(open_hdr());
                send_byte({server_role, LEN7_EXT8});
                send_byte(8'($urandom_range(128, 255)));
                repeat (7) send_byte(8'($urandom));
            end
            7: begin
                send_byte(open_hdr());
                send_byte({!server_role, 7'($urandom_range(0, 125))});
            end
            default: begin
                send_frame(1'b1, msg_open ? OP_CONT : OP_BINARY, server_role,
                           64'h7FFF_FFFF_FFFF_FFFF, 6);
            end
        endcase
        for (n = 0; n < 12; n++) send_byte(8'($urandom));

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Covered %0d input items in both endpoint roles: %0d headers, %0d payload",
                 sent_items, header_count, byte_count);
        $display("bytes and %0d protocol errors (closing case %0d).", error_count, tail_case);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
design/wsfp_pkg.sv
design/wsfp_step.sv
design/websocket_frame_parser.sv
test/wsfp_frame_checker.sv
test/websocket_frame_parser_tb.sv
